// File: src/fvps_pkg.sv
// Shared types, constants and the entry compare for the feature/value pair sorter.
// Used by fvps_cell and feature_value_pair_sorter_unit; depends on nothing.
package fvps_pkg;

   // Store depth and key width
   localparam int CAPACITY     = 64;
   localparam int FEATURE_BITS = 16;

   // Field widths
   localparam int FEAT_W   = 16;
   localparam int EXID_W   = 20;
   localparam int VAL_W    = 32;
   localparam int STATUS_W = 2;
   localparam int REQ_DATA_W = ((FEAT_W + EXID_W + VAL_W + 7) / 8) * 8;
   localparam int RSP_DATA_W = ((FEAT_W + EXID_W + VAL_W + STATUS_W + 7) / 8) * 8;

   // Only the low FEATURE_BITS bits of a feature id are kept
   localparam logic [FEAT_W-1:0] FEAT_MASK = FEAT_W'((64'd1 << FEATURE_BITS) - 64'd1);

   // Request kinds
   localparam logic OP_INSERT = 1'b0;
   localparam logic OP_POP    = 1'b1;

   // Result status codes
   localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd2;

   typedef struct packed {
      logic [FEAT_W-1:0]        feat;
      logic signed [VAL_W-1:0]  val;
      logic [EXID_W-1:0]        exid;
   } fvps_entry_type;

   // Operation broadcast to every cell in the chain
   typedef struct packed {
      logic insert;
      logic pop;
   } fvps_ctrl_type;

   // True when a sorts strictly before b: feature, then signed value, then example id
   function automatic logic entry_less(input fvps_entry_type a, input fvps_entry_type b);
      logic result;
      if (a.feat != b.feat) begin
         result = (a.feat < b.feat);
      end else if (a.val != b.val) begin
         result = ($signed(a.val) < $signed(b.val));
      end else begin
         result = (a.exid < b.exid);
      end
      return result;
   endfunction

endpackage

// File: src/feature_value_pair_sorter_unit.sv
// Top level of the feature/value pair sorter: a chain of fvps_cell slots
// kept in order, plus the request decode and the result register. Uses fvps_pkg.
//
//   channel | ports    | tdata (low bit up)                          | tuser
//   --------+----------+---------------------------------------------+--------
//   request | req_*    | feature_index, example_index, value         | opcode
//   result  | rsp_*    | out_feature_index, out_example_index,       | -
//           |          | out_feature_value, status                   |
//
// Every cell compares the new entry with its own slot in parallel and shifts
// by one place, so a request is taken every cycle unless a result is stalled.
// A result appears in the register in the cycle after its request is taken.
// Reset clears the slot valid flags at once; no clearing pass is needed.
// A stalled result blocks new requests only while it waits in the register.
module feature_value_pair_sorter_unit
   import fvps_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // feature_index [15:0], example_index [35:16], value [67:36], zero pad
   input  logic [REQ_DATA_W-1:0] req_tdata,
   // opcode [0]
   input  logic                  req_tuser,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // out_feature_index [15:0], out_example_index [35:16],
   // out_feature_value [67:36], status [69:68], zero pad
   output logic [RSP_DATA_W-1:0] rsp_tdata
);

   logic           cell_lt    [CAPACITY];
   logic           cell_valid [CAPACITY];
   fvps_entry_type cell_entry [CAPACITY];

   logic           req_accept;
   logic           full, empty;
   fvps_ctrl_type  ctrl;
   fvps_entry_type new_entry;

   logic           rsp_valid_ff, rsp_valid_in;
   fvps_entry_type rsp_entry_ff, rsp_entry_in;
   logic [STATUS_W-1:0] rsp_status_ff, rsp_status_in;

   // Take a request whenever the result register is free or draining
   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign req_accept = req_tvalid && req_tready;

   assign full  = cell_valid[CAPACITY-1];
   assign empty = !cell_valid[0];

   // Unpack the request
   assign new_entry.feat = req_tdata[FEAT_W-1:0] & FEAT_MASK;
   assign new_entry.exid = req_tdata[FEAT_W+EXID_W-1:FEAT_W];
   assign new_entry.val  = req_tdata[FEAT_W+EXID_W+VAL_W-1:FEAT_W+EXID_W];

   assign ctrl.insert = req_accept && (req_tuser == OP_INSERT) && !full;
   assign ctrl.pop    = req_accept && (req_tuser == OP_POP) && !empty;

   // Chain of slots, each tied to its neighbors
   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic           nb_left_lt, nb_left_valid, nb_right_valid;
      fvps_entry_type nb_left_entry, nb_right_entry;

      if (i == 0) begin : g_head
         assign nb_left_lt    = 1'b0;
         assign nb_left_valid = 1'b0;
         assign nb_left_entry = '0;
      end else begin : g_mid
         assign nb_left_lt    = cell_lt[i-1];
         assign nb_left_valid = cell_valid[i-1];
         assign nb_left_entry = cell_entry[i-1];
      end

      if (i == CAPACITY-1) begin : g_tail
         assign nb_right_valid = 1'b0;
         assign nb_right_entry = '0;
      end else begin : g_body
         assign nb_right_valid = cell_valid[i+1];
         assign nb_right_entry = cell_entry[i+1];
      end

      fvps_cell u_cell (
         .clock       (clock),
         .reset       (reset),
         .ctrl        (ctrl),
         .new_entry   (new_entry),
         .left_lt     (nb_left_lt),
         .left_valid  (nb_left_valid),
         .left_entry  (nb_left_entry),
         .right_valid (nb_right_valid),
         .right_entry (nb_right_entry),
         .lt          (cell_lt[i]),
         .valid       (cell_valid[i]),
         .entry       (cell_entry[i])
      );
   end

   // Load a result on pop or dropped insert; drop it once taken
   always_comb begin
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_entry_in  = rsp_entry_ff;
      rsp_status_in = rsp_status_ff;
      if (req_accept) begin
         if (req_tuser == OP_POP) begin
            rsp_valid_in = 1'b1;
            if (empty) begin
               rsp_entry_in  = '0;
               rsp_status_in = STATUS_EMPTY;
            end else begin
               rsp_entry_in  = cell_entry[0];
               rsp_status_in = STATUS_OK;
            end
         end else if (full) begin
            rsp_valid_in  = 1'b1;
            rsp_entry_in  = '0;
            rsp_status_in = STATUS_FULL;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_entry_ff  <= rsp_entry_in;
      rsp_status_ff <= rsp_status_in;
   end

   // Pack the result
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RSP_DATA_W'({rsp_status_ff, rsp_entry_ff.val,
                                    rsp_entry_ff.exid, rsp_entry_ff.feat});

endmodule

// File: src/fvps_cell.sv
// One slot of the sorted chain: holds an entry and its valid flag.
// Depends on fvps_pkg for the entry type, control struct and compare.
module fvps_cell
   import fvps_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  fvps_ctrl_type  ctrl,
   input  fvps_entry_type new_entry,
   input  logic           left_lt,
   input  logic           left_valid,
   input  fvps_entry_type left_entry,
   input  logic           right_valid,
   input  fvps_entry_type right_entry,
   output logic           lt,
   output logic           valid,
   output fvps_entry_type entry
);

   logic           valid_ff, valid_in;
   fvps_entry_type entry_ff, entry_in;

   // New entry goes before this slot (an empty slot always yields)
   assign lt = !valid_ff || entry_less(new_entry, entry_ff);

   // Pick next content: shift right on insert, shift left on pop
   always_comb begin
      valid_in = valid_ff;
      entry_in = entry_ff;
      if (ctrl.insert && lt) begin
         if (left_lt) begin
            valid_in = left_valid;
            entry_in = left_entry;
         end else begin
            valid_in = 1'b1;
            entry_in = new_entry;
         end
      end else if (ctrl.pop) begin
         valid_in = right_valid;
         entry_in = right_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      entry_ff <= entry_in;
   end

   assign valid = valid_ff;
   assign entry = entry_ff;

endmodule

// File: tb/feature_value_pair_sorter_unit_tb.sv
// Self-checking bench for feature_value_pair_sorter_unit: drives insert and pop requests,
// tracks the sorted store in a scoreboard class and checks each popped entry and status.
// Depends on fvps_pkg and feature_value_pair_sorter_unit.
module feature_value_pair_sorter_unit_tb;
   import fvps_pkg::*;

   localparam int CYCLE_LIMIT = 200000;
   localparam int MAX_REPORTS = 10;

   typedef struct packed {
      logic [FEAT_W-1:0]       feat;
      logic [EXID_W-1:0]       exid;
      logic signed [VAL_W-1:0] val;
   } sorted_entry_type;

   typedef struct packed {
      logic [FEAT_W-1:0]       feat;
      logic [EXID_W-1:0]       exid;
      logic signed [VAL_W-1:0] val;
      logic [STATUS_W-1:0]     status;
   } pop_result_type;

   // Shadow of the sorted store plus the queue of results still owed by the block
   class sorted_pop_scoreboard;
      sorted_entry_type model_store[$];
      pop_result_type   predicted_rsp[$];
      int mismatches;
      int checked;
      int stored;
      int dropped;
      int popped;
      int empties;

      // Order: feature id, then signed value, then example id
      function bit sorts_before(sorted_entry_type a, sorted_entry_type b);
         if (a.feat != b.feat) begin
            return a.feat < b.feat;
         end
         if (a.val != b.val) begin
            return $signed(a.val) < $signed(b.val);
         end
         return a.exid < b.exid;
      endfunction

      function void note_request(logic op, sorted_entry_type e);
         pop_result_type r;
         int pos;
         r = '0;
         if (op == OP_INSERT) begin
            if (model_store.size() >= CAPACITY) begin
               // Drop the entry, report overflow
               r.status = STATUS_FULL;
               predicted_rsp.insert(predicted_rsp.size(), r);
               dropped++;
            end else begin
               // Place after every entry that does not sort after it
               e.feat = e.feat & FEAT_MASK;
               pos = 0;
               while (pos < model_store.size() && !sorts_before(e, model_store[pos])) begin
                  pos++;
               end
               model_store.insert(pos, e);
               stored++;
            end
         end else if (model_store.size() == 0) begin
            r.status = STATUS_EMPTY;
            predicted_rsp.insert(predicted_rsp.size(), r);
            empties++;
         end else begin
            e = model_store.pop_front();
            r.feat   = e.feat;
            r.exid   = e.exid;
            r.val    = e.val;
            r.status = STATUS_OK;
            predicted_rsp.insert(predicted_rsp.size(), r);
            popped++;
         end
      endfunction

      function void check_result(logic [RSP_DATA_W-1:0] data);
         pop_result_type want;
         pop_result_type got;
         got.feat   = data[15:0];
         got.exid   = data[35:16];
         got.val    = data[67:36];
         got.status = data[69:68];
         checked++;
         if (predicted_rsp.size() == 0) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS) begin
               $display("unexpected result: feat=%h exid=%h val=%h status=%0d",
                        got.feat, got.exid, got.val, got.status);
            end
            return;
         end
         want = predicted_rsp.pop_front();
         if (got.feat !== want.feat || got.exid !== want.exid ||
             got.val !== want.val || got.status !== want.status) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS) begin
               $display("result %0d: expected feat=%h exid=%h val=%h status=%0d",
                        checked, want.feat, want.exid, want.val, want.status);
               $display("            got      feat=%h exid=%h val=%h status=%0d",
                        got.feat, got.exid, got.val, got.status);
            end
         end
      endfunction
   endclass

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic                  req_tuser = 1'b0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;

   sorted_pop_scoreboard pop_scoreboard;
   int send_idle_pct = 0;
   int rsp_stall_pct = 0;
   int cycle_count = 0;

   feature_value_pair_sorter_unit dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Abort a hung run
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("** feature_value_pair_sorter_unit: FAILED **");
         $finish;
      end
   end

   // Check results taken at this edge, then pick the next stall
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            pop_scoreboard.check_result(rsp_tdata);
         end
         rsp_tready <= ($urandom_range(99) >= rsp_stall_pct);
      end
   end

   // Present one request and hold it until taken; valid stays high for a back-to-back request
   task automatic send_request(input logic op, input logic [FEAT_W-1:0] feat,
                               input logic [EXID_W-1:0] exid, input logic [VAL_W-1:0] val);
      sorted_entry_type e;
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= {{(REQ_DATA_W - FEAT_W - EXID_W - VAL_W){1'b0}}, val, exid, feat};
      do begin
         @(posedge clock);
      end while (!req_tready);
      e.feat = feat;
      e.exid = exid;
      e.val  = val;
      pop_scoreboard.note_request(op, e);
   endtask

   // Random request; keys lean toward small ranges so ties on every key level occur
   task automatic send_random(input int insert_pct);
      logic              op;
      logic [FEAT_W-1:0] feat;
      logic [EXID_W-1:0] exid;
      logic [VAL_W-1:0]  val;
      int                pick;
      op = ($urandom_range(99) < insert_pct) ? OP_INSERT : OP_POP;
      pick = $urandom_range(9);
      if (pick < 4) begin
         feat = FEAT_W'($urandom_range(3));
      end else if (pick == 4) begin
         feat = $urandom_range(1) ? '1 : '0;
      end else begin
         feat = FEAT_W'($urandom);
      end
      pick = $urandom_range(9);
      if (pick < 3) begin
         val = VAL_W'($urandom_range(8)) - 32'd4;
      end else if (pick == 3) begin
         case ($urandom_range(3))
            0: val = 32'h8000_0000;
            1: val = 32'h7FFF_FFFF;
            2: val = 32'h0001_0000;
            default: val = 32'h0000_0000;
         endcase
      end else begin
         val = VAL_W'($urandom);
      end
      pick = $urandom_range(9);
      if (pick < 4) begin
         exid = EXID_W'($urandom_range(3));
      end else if (pick == 4) begin
         exid = $urandom_range(1) ? '1 : '0;
      end else begin
         exid = EXID_W'($urandom);
      end
      send_request(op, feat, exid, val);
   endtask

   initial begin
      int idle_by_phase[4];
      int stall_by_phase[4];
      idle_by_phase  = '{0, 78, 0, 29};
      stall_by_phase = '{0, 0, 78, 29};
      pop_scoreboard = new();
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // Directed: pop on empty, key extremes, ties on value and example id, exact duplicates
      send_request(OP_POP,    16'h1234, 20'h5_6789, 32'hDEAD_BEEF);
      send_request(OP_INSERT, 16'hFFFF, 20'hF_FFFF, 32'h7FFF_FFFF);
      send_request(OP_INSERT, 16'h0000, 20'h0_0000, 32'h8000_0000);
      send_request(OP_INSERT, 16'h0000, 20'h0_0001, 32'h8000_0000);
      send_request(OP_INSERT, 16'h0000, 20'h0_0000, 32'hFFFF_FFFF);
      send_request(OP_INSERT, 16'h0000, 20'h0_0000, 32'h0000_0000);
      send_request(OP_INSERT, 16'h0007, 20'h0_0005, 32'h0001_8000);
      send_request(OP_INSERT, 16'h0007, 20'h0_0005, 32'h0001_8000);
      send_request(OP_INSERT, 16'h0007, 20'h0_0003, 32'h0001_8000);
      send_request(OP_INSERT, 16'h8000, 20'hA_AAAA, 32'h5555_5555);
      send_request(OP_INSERT, 16'h7FFF, 20'h5_5555, 32'hAAAA_AAAA);
      repeat (11) begin
         send_request(OP_POP, 16'hFFFF, 20'hF_FFFF, 32'hFFFF_FFFF);
      end
      send_request(OP_POP, 16'h0000, 20'h0_0000, 32'h0000_0000);

      // Random: per idle and stall setting, fill past capacity, mix, then drain past empty
      for (int p = 0; p < 4; p++) begin
         send_idle_pct = idle_by_phase[p];
         rsp_stall_pct = stall_by_phase[p];
         repeat (80) send_random(95);
         repeat (30) send_random(50);
         repeat (90) send_random(5);
      end
      req_tvalid <= 1'b0;

      // Drain outstanding results, then keep watching for stray results
      rsp_stall_pct = 0;
      while (pop_scoreboard.predicted_rsp.size() != 0) begin
         @(posedge clock);
      end
      repeat (8) @(posedge clock);

      $display("requests: %0d stored, %0d dropped on full, %0d popped, %0d pops on empty",
               pop_scoreboard.stored, pop_scoreboard.dropped,
               pop_scoreboard.popped, pop_scoreboard.empties);
      $display("%0d results checked over four idle/stall settings, %0d mismatches",
               pop_scoreboard.checked, pop_scoreboard.mismatches);
      if (pop_scoreboard.mismatches == 0) begin
         $display("** feature_value_pair_sorter_unit: PASSED **");
      end else begin
         $display("** feature_value_pair_sorter_unit: FAILED **");
      end
      $finish;
   end

endmodule

// File: sim.f
src/fvps_pkg.sv
src/fvps_cell.sv
src/feature_value_pair_sorter_unit.sv
tb/feature_value_pair_sorter_unit_tb.sv
